[hw/rtl/utf8dv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8dv_pkg
// Types, constants and helpers shared by the UTF-8 decoder and validator.
// ----------------------------------------------------------------------------
package utf8dv_pkg;

  localparam logic [1:0]  CFG_MAX_BYTES       = 2'd0;
  localparam logic [1:0]  CFG_ALLOW_EMPTY     = 2'd1;
  localparam logic [1:0]  CFG_REJECT_CONTROLS = 2'd2;

  localparam logic [20:0] REPLACEMENT_CHAR = 21'h00fffd;
  localparam logic [20:0] SURROGATE_LO     = 21'h00d800;
  localparam logic [20:0] SURROGATE_HI     = 21'h00dfff;
  localparam logic [20:0] CODE_POINT_MAX   = 21'h10ffff;
  localparam logic [20:0] MIN_TWO_BYTE     = 21'h000080;
  localparam logic [20:0] MIN_THREE_BYTE   = 21'h000800;
  localparam logic [20:0] MIN_FOUR_BYTE    = 21'h010000;
  localparam logic [20:0] DEL_CHAR         = 21'h00007f;
  localparam logic [20:0] FIRST_PRINTABLE  = 21'h000020;
  localparam logic [16:0] TALLY_MAX        = 17'h1ffff;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  seq_bytes;
    logic        decode_ok;
    logic        is_verdict;
    logic        string_valid;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [2:0]  seq_total;
    logic [1:0]  bytes_remaining;
    logic [20:0] value_accum;
    logic        string_failed;
    logic [16:0] byte_tally;
    logic        terminated;
  } state_t;

  typedef struct packed {
    logic [15:0] max_string_bytes;
    logic        accept_empty;
    logic        reject_controls;
  } cfg_t;

  function automatic result_t make_result(input logic [20:0] cp, input logic [2:0] len,
                                          input logic ok, input logic verdict,
                                          input logic valid);
    result_t r;
    r.code_point   = cp;
    r.seq_bytes    = len;
    r.decode_ok    = ok;
    r.is_verdict   = verdict;
    r.string_valid = valid;
    r.last_result  = 1'b0;
    return r;
  endfunction

  function automatic logic is_control(input logic [20:0] cp);
    return (cp < FIRST_PRINTABLE) || (cp == DEL_CHAR);
  endfunction

endpackage
`default_nettype wire

[hw/rtl/utf8dv_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8dv_step
// Per-byte decode: next string state and up to three ordered results.
// ----------------------------------------------------------------------------
module utf8dv_step (
  input  utf8dv_pkg::state_t         st,
  input  utf8dv_pkg::cfg_t           cfg,
  input  logic [7:0]                 data_byte,
  input  logic                       end_of_string,
  output utf8dv_pkg::state_t         st_next,
  output utf8dv_pkg::result_t [2:0]  res,
  output logic [1:0]                 res_count
);

  utf8dv_pkg::result_t [3:0] cand;
  logic [3:0]                cand_en;
  logic [20:0]               acc_v;
  logic [1:0]                rem_dec;
  logic                      bad_seq;
  logic                      valid;
  logic [2:0]                cnt;

  assign acc_v   = {st.value_accum[14:0], data_byte[5:0]};
  assign rem_dec = st.bytes_remaining - 2'd1;
  assign bad_seq = ((st.seq_total == 3'd2) && (acc_v < utf8dv_pkg::MIN_TWO_BYTE))   ||
                   ((st.seq_total == 3'd3) && (acc_v < utf8dv_pkg::MIN_THREE_BYTE)) ||
                   ((st.seq_total == 3'd4) && (acc_v < utf8dv_pkg::MIN_FOUR_BYTE))  ||
                   ((acc_v >= utf8dv_pkg::SURROGATE_LO) &&
                    (acc_v <= utf8dv_pkg::SURROGATE_HI))                            ||
                   (acc_v > utf8dv_pkg::CODE_POINT_MAX);

  always_comb begin
    st_next = st;
    cand_en = '0;
    valid   = 1'b0;
    cand[0] = utf8dv_pkg::make_result(utf8dv_pkg::REPLACEMENT_CHAR, 3'd1, 1'b0, 1'b0, 1'b0);
    cand[1] = cand[0];
    cand[2] = cand[0];
    cand[3] = cand[0];

    if (!st.terminated) begin
      if (data_byte == 8'h00) begin
        if (st.seq_total != 3'd0) begin
          cand_en[0]            = 1'b1;
          st_next.string_failed = 1'b1;
        end
        st_next.seq_total       = '0;
        st_next.bytes_remaining = '0;
        st_next.value_accum     = '0;
        st_next.terminated      = 1'b1;
      end else begin
        if (st.byte_tally != utf8dv_pkg::TALLY_MAX) begin
          st_next.byte_tally = st.byte_tally + 17'd1;
        end
        if ((st.seq_total != 3'd0) && (data_byte[7:6] == 2'b10)) begin
          st_next.value_accum     = acc_v;
          st_next.bytes_remaining = rem_dec;
          if (rem_dec == 2'd0) begin
            st_next.seq_total   = '0;
            st_next.value_accum = '0;
            cand_en[1]          = 1'b1;
            if (bad_seq) begin
              cand[1] = utf8dv_pkg::make_result(utf8dv_pkg::REPLACEMENT_CHAR, st.seq_total,
                                                1'b0, 1'b0, 1'b0);
              st_next.string_failed = 1'b1;
            end else begin
              cand[1] = utf8dv_pkg::make_result(acc_v, st.seq_total, 1'b1, 1'b0, 1'b0);
              if (cfg.reject_controls && utf8dv_pkg::is_control(acc_v)) begin
                st_next.string_failed = 1'b1;
              end
            end
          end
        end else begin
          // close any open sequence, then take the byte as a lead
          if (st.seq_total != 3'd0) begin
            cand_en[0]            = 1'b1;
            st_next.string_failed = 1'b1;
          end
          st_next.seq_total       = '0;
          st_next.bytes_remaining = '0;
          st_next.value_accum     = '0;
          if (data_byte[7] == 1'b0) begin
            cand_en[1] = 1'b1;
            cand[1]    = utf8dv_pkg::make_result({13'd0, data_byte}, 3'd1, 1'b1, 1'b0, 1'b0);
            if (cfg.reject_controls && utf8dv_pkg::is_control({13'd0, data_byte})) begin
              st_next.string_failed = 1'b1;
            end
          end else if (data_byte inside {[8'hc2:8'hdf]}) begin
            st_next.seq_total       = 3'd2;
            st_next.bytes_remaining = 2'd1;
            st_next.value_accum     = {16'd0, data_byte[4:0]};
          end else if (data_byte inside {[8'he0:8'hef]}) begin
            st_next.seq_total       = 3'd3;
            st_next.bytes_remaining = 2'd2;
            st_next.value_accum     = {17'd0, data_byte[3:0]};
          end else if (data_byte inside {[8'hf0:8'hf4]}) begin
            st_next.seq_total       = 3'd4;
            st_next.bytes_remaining = 2'd3;
            st_next.value_accum     = {18'd0, data_byte[2:0]};
          end else begin
            cand_en[1]            = 1'b1;
            st_next.string_failed = 1'b1;
          end
        end
      end
    end

    if (end_of_string) begin
      if (st_next.seq_total != 3'd0) begin
        cand_en[2]            = 1'b1;
        st_next.string_failed = 1'b1;
      end
      valid = !st_next.string_failed &&
              (st_next.byte_tally <= {1'b0, cfg.max_string_bytes}) &&
              (cfg.accept_empty || (st_next.byte_tally != 17'd0));
      cand[3]    = utf8dv_pkg::make_result(21'd0, 3'd0, 1'b0, 1'b1, valid);
      cand_en[3] = 1'b1;
      st_next    = '0;
    end
  end

  // pack enabled results in order, mark the final one
  always_comb begin
    res = '0;
    cnt = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_en[i] && (cnt < 3'd3)) begin
        res[cnt[1:0]] = cand[i];
        cnt           = cnt + 3'd1;
      end
    end
    if (cnt != 3'd0) begin
      res[cnt[1:0] - 2'd1].last_result = 1'b1;
    end
    res_count = cnt[1:0];
  end

endmodule
`default_nettype wire

[hw/rtl/utf8_decode_validate.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_decode_validate
// Streaming UTF-8 decoder with whole-string validation.
// ----------------------------------------------------------------------------
// One byte per request on the s_ side (tlast marks the final byte of a
// string). Each byte gives zero to three result requests on the m_ side:
// replacement for an abandoned sequence, the decoded code point (or U+FFFD)
// and, on a tlast byte, the verdict (tuser set). m_tlast marks the last
// result caused by a byte; a byte that gives no result gives no request.
// Decode is done in the cycle the byte is taken; results are registered. A
// byte with k results occupies the three-entry result buffer until its last
// result leaves, so a stream with one result per byte runs at one byte per
// cycle while m_tready is high, and the next byte is taken as the last
// buffered result leaves. With results buffered and m_tready low, the buffer
// holds and s_tready drops. Reset clears the string state and buffer and
// sets max_string_bytes 255, accept_empty 0, reject_controls 1. Registers
// are written through cfg_we/cfg_index/cfg_data; index 3 is ignored.
// ----------------------------------------------------------------------------
module utf8_decode_validate (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // code_point[20:0], seq_bytes[23:21], decode_ok[24],
                                 // string_valid[25], zero[31:26]
  output logic        m_tuser,   // is_verdict
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  utf8dv_pkg::cfg_t               cfg;
  utf8dv_pkg::state_t             st;
  utf8dv_pkg::state_t             st_next;
  utf8dv_pkg::result_t [2:0]      step_res;
  logic [1:0]                     step_count;
  utf8dv_pkg::result_t [2:0]      slots;
  logic [1:0]                     count;
  logic                           push;
  logic                           pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_string_bytes <= 16'd255;
      cfg.accept_empty     <= 1'b0;
      cfg.reject_controls  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        utf8dv_pkg::CFG_MAX_BYTES:       cfg.max_string_bytes <= cfg_data;
        utf8dv_pkg::CFG_ALLOW_EMPTY:     cfg.accept_empty     <= cfg_data[0];
        utf8dv_pkg::CFG_REJECT_CONTROLS: cfg.reject_controls  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  utf8dv_step u_step (
    .st            (st),
    .cfg           (cfg),
    .data_byte     (s_tdata),
    .end_of_string (s_tlast),
    .st_next       (st_next),
    .res           (step_res),
    .res_count     (step_count)
  );

  assign m_tvalid = (count != 2'd0);
  assign s_tready = (count == 2'd0) || ((count == 2'd1) && m_tready);
  assign push     = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= '0;
      count <= '0;
    end else if (push) begin
      st    <= st_next;
      count <= step_count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots <= step_res;
    end else if (pop) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

  assign m_tdata = {6'd0, slots[0].string_valid, slots[0].decode_ok,
                    slots[0].seq_bytes, slots[0].code_point};
  assign m_tuser = slots[0].is_verdict;
  assign m_tlast = slots[0].last_result;

  a_no_result_no_request: assert property (@(posedge clk) disable iff (rst)
    push && (step_count == 2'd0) |=> !m_tvalid)
    else $error("request shown for a byte with no result");

  a_verdict_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("verdict not marked as last result");

  a_seq_consistent: assert property (@(posedge clk) disable iff (rst)
    (st.seq_total == 3'd0) == (st.bytes_remaining == 2'd0))
    else $error("sequence length and remaining count disagree");

  a_terminated_closed: assert property (@(posedge clk) disable iff (rst)
    st.terminated |-> (st.seq_total == 3'd0))
    else $error("sequence open after terminator");

endmodule
`default_nettype wire

[dv/utf8_decode_validate_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decode_validate_checker
// Watches the byte, result and register ports of the UTF-8 decoder, keeps
// its own decoder state and register copies, predicts the result requests
// of every accepted byte and compares each accepted result with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module utf8_decode_validate_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // code_point[20:0], seq_bytes[23:21], decode_ok[24],
                                 // string_valid[25], zero[31:26]
  input  logic        m_tuser,   // is_verdict
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  logic [15:0] lim;
  logic        empty_ok;
  logic        ctl_reject;

  logic [2:0]  seq_len;
  logic [1:0]  need;
  logic [20:0] accum;
  logic        str_bad;
  logic [16:0] tally;
  logic        ended;

  utf8dv_pkg::result_t expected_results[$];
  int                  n_new;
  utf8dv_pkg::result_t got;
  utf8dv_pkg::result_t want;
  logic                bad;

  task automatic clear_string();
    seq_len = 3'd0;
    need    = 2'd0;
    accum   = 21'd0;
    str_bad = 1'b0;
    tally   = 17'd0;
    ended   = 1'b0;
  endtask

  task automatic post(input logic [20:0] cp, input logic [2:0] len, input logic ok,
                      input logic verdict, input logic valid);
    utf8dv_pkg::result_t r;
    r.code_point   = cp;
    r.seq_bytes    = len;
    r.decode_ok    = ok;
    r.is_verdict   = verdict;
    r.string_valid = valid;
    r.last_result  = 1'b0;
    expected_results.push_back(r);
    n_new++;
  endtask

  task automatic accept_cp(input logic [20:0] cp, input logic [2:0] len);
    if (ctl_reject && (cp < utf8dv_pkg::FIRST_PRINTABLE || cp == utf8dv_pkg::DEL_CHAR))
      str_bad = 1'b1;
    post(cp, len, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic reject(input logic [2:0] len);
    str_bad = 1'b1;
    post(utf8dv_pkg::REPLACEMENT_CHAR, len, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic abandon_open();
    if (seq_len != 3'd0) begin
      reject(3'd1);
      seq_len = 3'd0;
      need    = 2'd0;
      accum   = 21'd0;
    end
  endtask

  task automatic start_seq(input logic [7:0] b);
    if (b < 8'h80) begin
      accept_cp({13'd0, b}, 3'd1);
    end else if (b >= 8'hc2 && b <= 8'hdf) begin
      seq_len = 3'd2; need = 2'd1; accum = {16'd0, b[4:0]};
    end else if (b >= 8'he0 && b <= 8'hef) begin
      seq_len = 3'd3; need = 2'd2; accum = {17'd0, b[3:0]};
    end else if (b >= 8'hf0 && b <= 8'hf4) begin
      seq_len = 3'd4; need = 2'd3; accum = {18'd0, b[2:0]};
    end else begin
      reject(3'd1);
    end
  endtask

  task automatic extend_seq(input logic [7:0] b);
    logic [20:0] v;
    logic [2:0]  len;
    logic        over;
    v     = {accum[14:0], b[5:0]};
    accum = v;
    need  = need - 2'd1;
    if (need == 2'd0) begin
      len  = seq_len;
      over = (len == 3'd2 && v < utf8dv_pkg::MIN_TWO_BYTE) ||
             (len == 3'd3 && v < utf8dv_pkg::MIN_THREE_BYTE) ||
             (len == 3'd4 && v < utf8dv_pkg::MIN_FOUR_BYTE);
      seq_len = 3'd0;
      accum   = 21'd0;
      if (over || (v >= utf8dv_pkg::SURROGATE_LO && v <= utf8dv_pkg::SURROGATE_HI) ||
          v > utf8dv_pkg::CODE_POINT_MAX)
        reject(len);
      else
        accept_cp(v, len);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eos);
    utf8dv_pkg::result_t r;
    logic                valid;
    n_new = 0;
    if (!ended) begin
      if (b == 8'h00) begin
        abandon_open();
        ended = 1'b1;
      end else begin
        if (tally != utf8dv_pkg::TALLY_MAX)
          tally = tally + 17'd1;
        if (seq_len != 3'd0 && b[7:6] == 2'b10) begin
          extend_seq(b);
        end else begin
          abandon_open();
          start_seq(b);
        end
      end
    end
    if (eos) begin
      abandon_open();
      valid = !str_bad && tally <= {1'b0, lim} && (empty_ok || tally != 17'd0);
      post(21'd0, 3'd0, 1'b0, 1'b1, valid);
      clear_string();
    end
    if (n_new > 0) begin
      r = expected_results.pop_back();
      r.last_result = 1'b1;
      expected_results.push_back(r);
    end
  endtask

  task automatic note_failure(input string what);
    if (fail_count < 10) begin
      $display("%0t %s: expected cp=%h len=%0d ok=%b verdict=%b valid=%b last=%b",
               $realtime, what, want.code_point, want.seq_bytes, want.decode_ok,
               want.is_verdict, want.string_valid, want.last_result);
      $display("    got cp=%h len=%0d ok=%b verdict=%b valid=%b last=%b pad=%h",
               got.code_point, got.seq_bytes, got.decode_ok, got.is_verdict,
               got.string_valid, got.last_result, m_tdata[31:26]);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lim        = 16'd255;
      empty_ok   = 1'b0;
      ctl_reject = 1'b1;
      clear_string();
      expected_results.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          utf8dv_pkg::CFG_MAX_BYTES:       lim        = cfg_data;
          utf8dv_pkg::CFG_ALLOW_EMPTY:     empty_ok   = cfg_data[0];
          utf8dv_pkg::CFG_REJECT_CONTROLS: ctl_reject = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        decode_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got.code_point   = m_tdata[20:0];
        got.seq_bytes    = m_tdata[23:21];
        got.decode_ok    = m_tdata[24];
        got.string_valid = m_tdata[25];
        got.is_verdict   = m_tuser;
        got.last_result  = m_tlast;
        checked++;
        if (expected_results.size() == 0) begin
          want = '0;
          note_failure("unexpected result");
        end else begin
          want = expected_results.pop_front();
          bad  = (got.code_point !== want.code_point) || (got.seq_bytes !== want.seq_bytes) ||
                 (got.decode_ok !== want.decode_ok) || (got.is_verdict !== want.is_verdict) ||
                 (got.string_valid !== want.string_valid) ||
                 (got.last_result !== want.last_result) || (m_tdata[31:26] !== 6'd0);
          if (bad)
            note_failure("result mismatch");
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

[dv/utf8_decode_validate_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decode_validate_tb
// Drives strings of bytes into the UTF-8 decoder: a short directed set of
// edge cases, then random strings, mostly well formed with random flaws,
// over several register settings. Both sides pause at random. The checker
// does the prediction.
// ----------------------------------------------------------------------------
module utf8_decode_validate_tb;

  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int          fail_count;
  int          pending;
  int          checked;

  logic        calm;
  int          sink_stall;
  int          n_bytes;
  int          n_strings;
  int          n_settings;
  logic [7:0]  text[$];

  utf8_decode_validate dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  utf8_decode_validate_checker decode_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  initial begin
    m_tready   = 1'b0;
    sink_stall = 0;
    forever begin
      @(negedge clk);
      if (sink_stall > 0) begin
        m_tready <= 1'b0;
        sink_stall--;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        m_tready <= 1'b0;
        sink_stall = gap_len() - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 60) ? 0 : gap_len();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tlast  <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    n_bytes++;
  endtask

  task automatic send_text();
    foreach (text[i])
      send_byte(text[i], i == text.size() - 1);
    text.delete();
    n_strings++;
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] lim, input logic empty_ok,
                            input logic ctl_reject);
    logic [15:0] junk;
    junk = 16'($urandom);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_data  <= junk;
    @(negedge clk);
    cfg_index <= utf8dv_pkg::CFG_MAX_BYTES;
    cfg_data  <= lim;
    junk = 16'($urandom);
    @(negedge clk);
    cfg_index <= utf8dv_pkg::CFG_ALLOW_EMPTY;
    cfg_data  <= {junk[15:1], empty_ok};
    junk = 16'($urandom);
    @(negedge clk);
    cfg_index <= utf8dv_pkg::CFG_REJECT_CONTROLS;
    cfg_data  <= {junk[15:1], ctl_reject};
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // encodes cp in len bytes whether or not that is the shortest form
  task automatic put_seq(input logic [20:0] cp, input int len);
    case (len)
      1: text.push_back(cp[7:0]);
      2: begin
        text.push_back({3'b110, cp[10:6]});
        text.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text.push_back({4'b1110, cp[15:12]});
        text.push_back({2'b10, cp[11:6]});
        text.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text.push_back({5'b11110, cp[20:18]});
        text.push_back({2'b10, cp[17:12]});
        text.push_back({2'b10, cp[11:6]});
        text.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic add_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)
      put_seq(21'($urandom_range(32'h20, 32'h7e)), 1);
    else if (r < 48)
      put_seq($urandom_range(0, 1) ? 21'h7f : 21'($urandom_range(32'h01, 32'h1f)), 1);
    else if (r < 68)
      put_seq(21'($urandom_range(32'h80, 32'h7ff)), 2);
    else if (r < 86)
      put_seq(21'($urandom_range(32'h800, 32'hffff)), 3);
    else
      put_seq(21'($urandom_range(32'h10000, 32'h10ffff)), 4);
  endtask

  task automatic add_flaw();
    int len;
    case ($urandom_range(0, 7))
      0: text.push_back(8'($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hc1)
                                                 : $urandom_range(8'hf5, 8'hff)));
      1: begin
        len = $urandom_range(2, 4);
        if (len == 2)      put_seq(21'($urandom_range(0, 32'h7f)), 2);
        else if (len == 3) put_seq(21'($urandom_range(0, 32'h7ff)), 3);
        else               put_seq(21'($urandom_range(0, 32'hffff)), 4);
      end
      2: put_seq(21'($urandom_range(32'hd800, 32'hdfff)), 3);
      3: put_seq(21'($urandom_range(32'h110000, 32'h1fffff)), 4);
      4: begin
        len = $urandom_range(2, 4);
        if (len == 2)      put_seq(21'($urandom_range(32'h80, 32'h7ff)), 2);
        else if (len == 3) put_seq(21'($urandom_range(32'h800, 32'hffff)), 3);
        else               put_seq(21'($urandom_range(32'h10000, 32'h10ffff)), 4);
        repeat ($urandom_range(1, len - 1)) void'(text.pop_back());
      end
      5: text.push_back(8'($urandom_range(8'h80, 8'hbf)));
      6: begin
        text.push_back(8'h00);
        repeat ($urandom_range(0, 3)) text.push_back(8'($urandom));
      end
      default: text.push_back(8'($urandom));
    endcase
  endtask

  task automatic random_string();
    int r;
    int n_chars;
    logic noisy;
    r = $urandom_range(0, 99);
    n_chars = (r < 8) ? 0 : (r < 90) ? $urandom_range(1, 6) : $urandom_range(7, 24);
    noisy = $urandom_range(0, 99) < 35;
    repeat (n_chars) begin
      if (noisy && $urandom_range(0, 99) < 30) add_flaw();
      else add_char();
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      if (text.size() == 0) text.push_back(8'h00);
    end else if (r < 85) begin
      text.push_back(8'h00);
    end else begin
      text.push_back(8'h00);
      repeat ($urandom_range(1, 3)) text.push_back(8'($urandom));
    end
    send_text();
  endtask

  task automatic run_phase(input logic [15:0] lim, input logic empty_ok,
                           input logic ctl_reject, input int target);
    int start;
    settle();
    set_config(lim, empty_ok, ctl_reject);
    start = n_bytes;
    while (n_bytes - start < target) begin
      calm = $urandom_range(0, 99) < 15;
      random_string();
    end
    calm = 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = 8'h00;
    s_tlast    = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = utf8dv_pkg::CFG_MAX_BYTES;
    cfg_data   = 16'h0000;
    calm       = 1'b0;
    n_bytes    = 0;
    n_strings  = 0;
    n_settings = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // edge cases on the reset settings
    text = '{8'h41};
    send_text();
    text = '{8'h00};
    send_text();
    text = '{8'hc2, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
    send_text();
    text = '{8'he0, 8'h80, 8'h80, 8'hf4, 8'h90, 8'h80, 8'h80};
    send_text();
    text = '{8'hc3, 8'h41, 8'hc3, 8'h00, 8'h55, 8'he2};
    send_text();
    text = '{8'hf0, 8'h9f};
    send_text();
    text = '{8'h7f, 8'h80, 8'hff};
    send_text();

    run_phase(16'd255, 1'b0, 1'b1, 70);
    run_phase(16'd0, 1'b1, 1'b0, 70);
    run_phase(16'hffff, 1'b1, 1'b1, 70);
    run_phase(16'($urandom_range(1, 12)), 1'b0, 1'b0, 70);
    run_phase(16'($urandom_range(1, 40)), 1'($urandom), 1'($urandom), 70);
    run_phase(16'($urandom), 1'b1, 1'b1, 60);
    run_phase(16'd4, 1'b0, 1'b1, 40);

    settle();
    repeat (8) @(negedge clk);
    $display("%0d bytes in %0d strings under %0d register settings, %0d results compared",
             n_bytes, n_strings, n_settings, checked);
    $display("covered edge cases, malformed and cut-off sequences, terminators and tight limits");
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/utf8dv_pkg.sv
hw/rtl/utf8dv_step.sv
hw/rtl/utf8_decode_validate.sv
dv/utf8_decode_validate_checker.sv
dv/utf8_decode_validate_tb.sv
